### rtl/smvm_pkg.sv
package smvm_pkg;

    // Fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int ADDR_IN_W  = 16;
    localparam int LEN_W      = 17;
    localparam int SLOT_OUT_W = 6;
    localparam int COUNT_OUT_W = 7;

    // Defaults for the top-level parameters
    localparam int VOICE_SLOTS_DEF      = 30;
    localparam int SAMPLE_MEM_DEPTH_DEF = 65536;

    // Function codes of an input word
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_QUEUE = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // Sequencer states
    typedef enum logic [6:0] {
        ST_IDLE       = 7'b0000001,
        ST_MOD_WAIT   = 7'b0000010,
        ST_Q_SCAN     = 7'b0000100,
        ST_TICK_CHK   = 7'b0001000,
        ST_TICK_VOICE = 7'b0010000,
        ST_TICK_ACC   = 7'b0100000,
        ST_FINISH     = 7'b1000000
    } state_t;

endpackage

### rtl/sample_voice_mixer_top.sv
// Sample voice mixer. Holds a sample memory and a table of voice slots; each input word
// writes a sample (func 0), queues a sound in the lowest free slot (func 1) or produces
// one mixed sample from all active voices (func 2), and returns exactly one result word.
// Words are handled one at a time by a small sequencer; a result waits in an output
// register, so the next word can be taken while it is still pending. A write or a queue
// first passes its address through the shared reciprocal address reduction unit; a queue
// then scans the slots from the lowest, up to VOICE_SLOTS. A tick walks the slots in
// order, checking each idle slot and, for each active slot, reading the voice table,
// reading the sample memory, then accumulating and writing back. An unused func code goes
// straight to the finish state. A result is held in the finish state while the previous
// result still waits in the output register. No clearing pass after reset.
module sample_voice_mixer_top
    import smvm_pkg::*;
#(
    parameter int VOICE_SLOTS      = VOICE_SLOTS_DEF,
    parameter int SAMPLE_MEM_DEPTH = SAMPLE_MEM_DEPTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   func,
    input  logic [ADDR_IN_W-1:0]         mem_addr,
    input  logic signed [SAMPLE_W-1:0]   sample_in,
    input  logic [ADDR_IN_W-1:0]         sound_start,
    input  logic [LEN_W-1:0]             sound_length,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [SAMPLE_W-1:0]   mixed_sample,
    output logic                         queued_ok,
    output logic [SLOT_OUT_W-1:0]        slot_taken,
    output logic [COUNT_OUT_W-1:0]       active_voices
);

    localparam int ADDR_W = $clog2(SAMPLE_MEM_DEPTH);
    localparam int SLOT_W = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(VOICE_SLOTS + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(VOICE_SLOTS - 1);
    localparam logic [ADDR_W:0]   DEPTH_WRAP = (ADDR_W + 1)'(SAMPLE_MEM_DEPTH);

    // Control state
    state_t                 state_reg, state_next;
    logic [SLOT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [VOICE_SLOTS-1:0] active_reg, active_next;
    logic                   out_valid_reg, out_valid_next;

    // Per-word working registers
    logic [1:0]                  func_reg, func_next;
    logic signed [SAMPLE_W-1:0]  sample_reg, sample_next;
    logic [LEN_W-1:0]            len_reg, len_next;
    logic [ADDR_W-1:0]           base_reg, base_next;
    logic signed [SAMPLE_W-1:0]  mix_reg, mix_next;
    logic                        ok_reg, ok_next;
    logic [SLOT_W-1:0]           slot_reg, slot_next;

    // Output register
    logic signed [SAMPLE_W-1:0]  out_mix_reg, out_mix_next;
    logic                        out_ok_reg, out_ok_next;
    logic [SLOT_OUT_W-1:0]       out_slot_reg, out_slot_next;
    logic [COUNT_OUT_W-1:0]      out_count_reg, out_count_next;

    // Memories and their read registers
    logic signed [SAMPLE_W-1:0]  sample_mem [SAMPLE_MEM_DEPTH];
    logic [ADDR_W-1:0]           voice_addr_mem [VOICE_SLOTS];
    logic [LEN_W-1:0]            voice_len_mem [VOICE_SLOTS];
    logic [LEN_W-1:0]            voice_pos_mem [VOICE_SLOTS];
    logic signed [SAMPLE_W-1:0]  sample_rd_reg;
    logic [ADDR_W-1:0]           voice_addr_rd_reg;
    logic [LEN_W-1:0]            voice_len_rd_reg;
    logic [LEN_W-1:0]            voice_pos_rd_reg;

    // Memory write controls
    logic                  smem_we;
    logic                  vmem_we;
    logic [ADDR_W-1:0]     vmem_addr_wd;
    logic [LEN_W-1:0]      vmem_len_wd;
    logic [LEN_W-1:0]      vmem_pos_wd;

    // Address reduction unit
    logic                  mod_start;
    logic [ADDR_IN_W-1:0]  mod_value;
    logic                  mod_done;
    logic [ADDR_W-1:0]     mod_result;

    // Tick datapath
    logic signed [SAMPLE_W:0] mix_sum;
    logic signed [SAMPLE_W-1:0] mix_sat;
    logic [LEN_W-1:0]      pos_inc;
    logic [ADDR_W:0]       addr_inc;
    logic [ADDR_W-1:0]     addr_wrapped;
    logic                  in_accept;
    logic                  out_free;

    assign in_accept = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || out_ready;
    assign mod_start = in_accept && ((func == FUNC_WRITE) || (func == FUNC_QUEUE));
    assign mod_value = (func == FUNC_WRITE) ? mem_addr : sound_start;

    smvm_addr_mod #(
        .SAMPLE_MEM_DEPTH (SAMPLE_MEM_DEPTH),
        .ADDR_W           (ADDR_W)
    ) u_addr_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mod_start),
        .value  (mod_value),
        .done   (mod_done),
        .result (mod_result)
    );

    // Saturating add of the current voice sample
    assign mix_sum = {mix_reg[SAMPLE_W-1], mix_reg} + {sample_rd_reg[SAMPLE_W-1], sample_rd_reg};
    always_comb
    begin
        if (mix_sum[SAMPLE_W] != mix_sum[SAMPLE_W-1])
        begin
            mix_sat = mix_sum[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                        : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        else
        begin
            mix_sat = mix_sum[SAMPLE_W-1:0];
        end
    end

    // Voice advance: position and wrapped read address
    assign pos_inc      = voice_pos_rd_reg + 1'b1;
    assign addr_inc     = {1'b0, voice_addr_rd_reg} + 1'b1;
    assign addr_wrapped = (addr_inc == DEPTH_WRAP) ? '0 : addr_inc[ADDR_W-1:0];

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        active_next    = active_reg;
        out_valid_next = out_valid_reg;
        func_next      = func_reg;
        sample_next    = sample_reg;
        len_next       = len_reg;
        base_next      = base_reg;
        mix_next       = mix_reg;
        ok_next        = ok_reg;
        slot_next      = slot_reg;
        out_mix_next   = out_mix_reg;
        out_ok_next    = out_ok_reg;
        out_slot_next  = out_slot_reg;
        out_count_next = out_count_reg;
        smem_we        = 1'b0;
        vmem_we        = 1'b0;
        vmem_addr_wd   = addr_wrapped;
        vmem_len_wd    = voice_len_rd_reg;
        vmem_pos_wd    = pos_inc;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    func_next   = func;
                    sample_next = sample_in;
                    len_next    = sound_length;
                    mix_next    = '0;
                    ok_next     = 1'b0;
                    slot_next   = '0;
                    idx_next    = '0;
                    if ((func == FUNC_WRITE) || (func == FUNC_QUEUE))
                    begin
                        state_next = ST_MOD_WAIT;
                    end
                    else if (func == FUNC_TICK)
                    begin
                        state_next = ST_TICK_CHK;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_MOD_WAIT:
            begin
                if (mod_done)
                begin
                    base_next = mod_result;
                    if (func_reg == FUNC_WRITE)
                    begin
                        smem_we    = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_Q_SCAN;
                    end
                end
            end

            // Lowest free slot, one slot a cycle
            ST_Q_SCAN:
            begin
                if (!active_reg[idx_reg])
                begin
                    vmem_we              = 1'b1;
                    vmem_addr_wd         = base_reg;
                    vmem_len_wd          = len_reg;
                    vmem_pos_wd          = '0;
                    active_next[idx_reg] = 1'b1;
                    count_next           = count_reg + 1'b1;
                    ok_next              = 1'b1;
                    slot_next            = idx_reg;
                    state_next           = ST_FINISH;
                end
                else if (idx_reg == LAST_SLOT)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // Voice table read is issued at idx_reg in this state
            ST_TICK_CHK:
            begin
                if (active_reg[idx_reg])
                begin
                    state_next = ST_TICK_VOICE;
                end
                else if (idx_reg == LAST_SLOT)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // Sample read is issued at the voice address in this state
            ST_TICK_VOICE:
            begin
                state_next = ST_TICK_ACC;
            end

            ST_TICK_ACC:
            begin
                if (voice_pos_rd_reg < voice_len_rd_reg)
                begin
                    mix_next = mix_sat;
                end
                vmem_we = 1'b1;
                if (pos_inc >= voice_len_rd_reg)
                begin
                    active_next[idx_reg] = 1'b0;
                    count_next           = count_reg - 1'b1;
                end
                if (idx_reg == LAST_SLOT)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_TICK_CHK;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_mix_next   = mix_reg;
                    out_ok_next    = ok_reg;
                    out_slot_next  = SLOT_OUT_W'(slot_reg);
                    out_count_next = COUNT_OUT_W'(count_reg);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        sample_reg    <= sample_next;
        len_reg       <= len_next;
        base_reg      <= base_next;
        mix_reg       <= mix_next;
        ok_reg        <= ok_next;
        slot_reg      <= slot_next;
        out_mix_reg   <= out_mix_next;
        out_ok_reg    <= out_ok_next;
        out_slot_reg  <= out_slot_next;
        out_count_reg <= out_count_next;
    end

    // Sample memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (smem_we)
        begin
            sample_mem[mod_result] <= sample_reg;
        end
        sample_rd_reg <= sample_mem[voice_addr_rd_reg];
    end

    // Voice table: written and read at the current slot
    always_ff @(posedge clk)
    begin
        if (vmem_we)
        begin
            voice_addr_mem[idx_reg] <= vmem_addr_wd;
            voice_len_mem[idx_reg]  <= vmem_len_wd;
            voice_pos_mem[idx_reg]  <= vmem_pos_wd;
        end
        voice_addr_rd_reg <= voice_addr_mem[idx_reg];
        voice_len_rd_reg  <= voice_len_mem[idx_reg];
        voice_pos_rd_reg  <= voice_pos_mem[idx_reg];
    end

    assign out_valid     = out_valid_reg;
    assign mixed_sample  = out_mix_reg;
    assign queued_ok     = out_ok_reg;
    assign slot_taken    = out_slot_reg;
    assign active_voices = out_count_reg;

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(active_reg)))
        else $error("active voice count out of step with slot flags");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(VOICE_SLOTS))
        else $error("active voice count above slot count");

    a_queued_slot_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && ok_reg) |-> active_reg[slot_reg])
        else $error("reported slot is not marked active");

    a_mod_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == ST_MOD_WAIT))
        else $error("address reduction finished outside its wait state");

endmodule

### rtl/smvm_addr_mod.sv
module smvm_addr_mod
    import smvm_pkg::*;
#(
    parameter int SAMPLE_MEM_DEPTH = SAMPLE_MEM_DEPTH_DEF,
    parameter int ADDR_W           = $clog2(SAMPLE_MEM_DEPTH)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [ADDR_IN_W-1:0] value,
    output logic                 done,
    output logic [ADDR_W-1:0]    result
);

    // Reciprocal remainder in two steps: quotient = (value * RECIP) >> SHIFT, exact for
    // every ADDR_IN_W-bit value since RECIP * depth exceeds 2^SHIFT by less than 2^ADDR_W;
    // then remainder = value - quotient * depth
    localparam int     SHIFT   = ADDR_IN_W + ADDR_W;
    localparam int     RECIP_W = ADDR_IN_W + 2;
    localparam int     PROD_W  = SHIFT + ADDR_IN_W;
    localparam int     REM_W   = (ADDR_W > ADDR_IN_W) ? ADDR_W : ADDR_IN_W;
    localparam longint RECIP   = ((longint'(1) << SHIFT) + longint'(SAMPLE_MEM_DEPTH) - 1)
                                 / longint'(SAMPLE_MEM_DEPTH);
    localparam logic [RECIP_W-1:0]   RECIP_K = RECIP_W'(RECIP);
    localparam logic [ADDR_IN_W-1:0] DEPTH_K = ADDR_IN_W'(SAMPLE_MEM_DEPTH);

    logic                 busy_reg;
    logic                 done_reg;
    logic [ADDR_IN_W-1:0] val_reg;
    logic [ADDR_IN_W-1:0] quot_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [PROD_W-1:0]    prod;
    logic [ADDR_IN_W-1:0] quot_by_depth;

    // 16 x 18 constant product; quotient never exceeds the input value
    assign prod          = PROD_W'(value) * PROD_W'(RECIP_K);
    assign quot_by_depth = quot_reg * DEPTH_K;

    // Step sequencing and handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start;
            done_reg <= busy_reg;
        end
    end

    // Quotient, then remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= value;
            quot_reg <= prod[SHIFT +: ADDR_IN_W];
        end
        if (busy_reg)
        begin
            rem_reg <= REM_W'(val_reg - quot_by_depth);
        end
    end

    assign done   = done_reg;
    assign result = rem_reg[ADDR_W-1:0];

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("address reduction restarted while busy");

    a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ({1'b0, rem_reg} < (REM_W + 1)'(SAMPLE_MEM_DEPTH)))
        else $error("reduced address not below memory depth");

    a_done_alone: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("address reduction done while still busy");

endmodule
